// ----- hw/rtl/plm_pkg.sv -----
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and constants of the two-sided piecewise linear map.
// ----------------------------------------------------------------------------
`default_nettype none

package plm_pkg;

	localparam int POINTS    = 8;
	localparam int DW        = 16;
	localparam int IDX_W     = 3;
	localparam int NUM_W     = 34;
	localparam int DEN_W     = 17;
	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 1;

	localparam logic [1:0] OP_QUERY    = 2'd0;
	localparam logic [1:0] OP_LOAD_POS = 2'd1;
	localparam logic [1:0] OP_LOAD_NEG = 2'd2;

	typedef logic signed [DW-1:0] q88_t;

	typedef struct packed {
		q88_t pd;
		q88_t ps;
		q88_t nd;
		q88_t ns;
	} entry_t;

	typedef struct packed {
		logic   vld;
		logic   neg;
		logic   have_prev;
		logic   done;
		logic   seg;
		q88_t   d;
		q88_t   d0;
		q88_t   d1;
		q88_t   s0;
		q88_t   s1;
		entry_t prev;
	} tok_t;

endpackage

`default_nettype wire

// ----- hw/rtl/plm_cell.sv -----
// ----------------------------------------------------------------------------
// plm_cell
// One breakpoint of both tables; checks the passing query word against the
// segment that ends here and hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_pos,
	input  wire logic          wr_neg,
	input  wire plm_pkg::q88_t wr_d,
	input  wire plm_pkg::q88_t wr_s,
	input  wire plm_pkg::tok_t tin,
	output plm_pkg::tok_t      tout
);
	import plm_pkg::*;

	entry_t ent_q;
	tok_t   tok_q;
	tok_t   nxt;

	always_ff @(posedge clk) begin
		if (wr_pos) begin
			ent_q.pd <= wr_d;
			ent_q.ps <= wr_s;
		end
		if (wr_neg) begin
			ent_q.nd <= wr_d;
			ent_q.ns <= wr_s;
		end
	end

	always_comb begin
		nxt           = tin;
		nxt.have_prev = 1'b1;
		nxt.prev      = ent_q;
		if (tin.vld && !tin.done) begin
			if (!tin.have_prev) begin
				if (tin.d == '0) begin
					nxt.done = 1'b1;
				end else if (!tin.neg && tin.d <= ent_q.pd) begin
					nxt.done = 1'b1;
				end else if (tin.neg && tin.d >= ent_q.nd) begin
					nxt.done = 1'b1;
				end
			end else if (!tin.neg) begin
				if (tin.d >= tin.prev.pd && tin.d <= ent_q.pd) begin
					nxt.done = 1'b1;
					nxt.seg  = 1'b1;
					nxt.d0   = tin.prev.pd;
					nxt.d1   = ent_q.pd;
					nxt.s0   = tin.prev.ps;
					nxt.s1   = ent_q.ps;
				end
			end else begin
				if (tin.d <= tin.prev.nd && tin.d >= ent_q.nd) begin
					nxt.done = 1'b1;
					nxt.seg  = 1'b1;
					nxt.d0   = tin.prev.nd;
					nxt.d1   = ent_q.nd;
					nxt.s0   = tin.prev.ns;
					nxt.s1   = ent_q.ns;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= nxt;
		end
	end

	assign tout = tok_q;

endmodule

`default_nettype wire

// ----- hw/rtl/plm_div.sv -----
// ----------------------------------------------------------------------------
// plm_div
// Serial restoring divider, one quotient bit a cycle, truncating toward zero
// and saturating positive results to a signed Q8.8 word.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [plm_pkg::NUM_W-1:0]    num,
	input  wire logic signed [plm_pkg::DEN_W-1:0]    den,
	output logic                                     done,
	output plm_pkg::q88_t                            quo
);
	import plm_pkg::*;

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

	dstate_t                state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   neg_q;
	logic [DEN_W-1:0]       mag_d_q;
	logic [DEN_W-1:0]       rem_q;
	logic [DIV_STEPS-1:0]   quo_q;
	logic                   done_q;
	q88_t                   res_q;

	logic [NUM_W-1:0]       mag_n;
	logic [DEN_W-1:0]       mag_d;
	logic [DEN_W:0]         trial;
	logic                   take;
	logic [DEN_W:0]         diff;
	logic [DW:0]            neg_quo;

	assign mag_n   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign mag_d   = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
	assign trial   = {rem_q, quo_q[DIV_STEPS-1]};
	assign take    = trial >= {1'b0, mag_d_q};
	assign diff    = trial - {1'b0, mag_d_q};
	assign neg_quo = (DW+1)'(0) - {1'b0, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == D_FIN);
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						neg_q   <= num[NUM_W-1] ^ den[DEN_W-1];
						mag_d_q <= mag_d;
						rem_q   <= mag_n[NUM_W-2:DIV_STEPS];
						quo_q   <= mag_n[DIV_STEPS-1:0];
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					quo_q <= {quo_q[DIV_STEPS-2:0], take};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					if (neg_q) begin
						res_q <= q88_t'(neg_quo[DW-1:0]);
					end else if (quo_q[DIV_STEPS-1]) begin
						res_q <= q88_t'({1'b0, {(DW-1){1'b1}}});
					end else begin
						res_q <= q88_t'(quo_q);
					end
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quo  = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/two_sided_piecewise_linear_map.sv -----
// ----------------------------------------------------------------------------
// two_sided_piecewise_linear_map
// Maps a signed Q8.8 distance to a Q8.8 steering value through ascending
// positive and descending negative breakpoint tables with interpolation.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                    tuser
// s_       in   [2:0] point_index, [18:3] distance_value, [1:0] opcode
//               [34:19] steer_value
// m_       out  [15:0] steering                          [0] saturated
//
// A load leaves the input ready, so the next word is taken right after it.
// A query walks the row of cells, two multiply steps, a start step, 16 divide steps, the
// divider's finish state and done register, a wait state and the output state; one that ends
// in a clamp or a fixed value goes from the cells to output; input is ready as its result is set.
// A result word waits in the output register; the next finished query holds until it drains.
// Reset clears control only; table entries hold garbage until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module two_sided_piecewise_linear_map (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [plm_pkg::S_TDATA_W-1:0]   s_tdata,  // point_index, distance_value, steer_value
	input  wire logic [plm_pkg::S_TUSER_W-1:0]   s_tuser,  // opcode
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [plm_pkg::M_TDATA_W-1:0]        m_tdata,  // steering
	output logic [plm_pkg::M_TUSER_W-1:0]        m_tuser   // saturated
);
	import plm_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_CHAIN, S_MUL0, S_MUL1, S_DIV, S_WAIT, S_OUT} state_t;

	state_t            state_q;
	logic              m_tvalid_q;
	logic [DW-1:0]     m_tdata_q;
	logic              m_tuser_q;
	q88_t              res_steer_q;
	logic              res_sat_q;
	q88_t              seg_d_q, seg_d0_q, seg_d1_q, seg_s0_q, seg_s1_q;
	logic signed [32:0] prod_q;
	logic signed [NUM_W-1:0] num_q;
	logic signed [DEN_W-1:0] den_q;

	logic [1:0]        in_op;
	logic [IDX_W-1:0]  in_idx;
	q88_t              in_d;
	q88_t              in_s;
	logic              accept;
	logic              ld_ok;
	tok_t              tok_in;
	tok_t              chain [POINTS+1];
	tok_t              tok_end;
	logic signed [DEN_W-1:0] da, db, wd;
	logic signed [32:0] pb;
	logic              div_start;
	logic              div_done;
	q88_t              div_quo;
	logic              out_free;

	assign in_op    = s_tuser;
	assign in_idx   = s_tdata[2:0];
	assign in_d     = q88_t'(s_tdata[18:3]);
	assign in_s     = q88_t'(s_tdata[34:19]);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign ld_ok    = int'(in_idx) < POINTS;

	always_comb begin
		tok_in     = '0;
		tok_in.vld = accept && (in_op == OP_QUERY);
		tok_in.neg = in_d[DW-1];
		tok_in.d   = in_d;
	end

	assign chain[0] = tok_in;

	for (genvar i = 0; i < POINTS; i++) begin : g_cell
		plm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wr_pos (accept && ld_ok && in_op == OP_LOAD_POS && int'(in_idx) == i),
			.wr_neg (accept && ld_ok && in_op == OP_LOAD_NEG && int'(in_idx) == i),
			.wr_d   (in_d),
			.wr_s   (in_s),
			.tin    (chain[i]),
			.tout   (chain[i+1])
		);
	end

	assign tok_end = chain[POINTS];
	assign wd      = DEN_W'(tok_end.d1) - DEN_W'(tok_end.d0);
	assign da      = DEN_W'(seg_d_q) - DEN_W'(seg_d0_q);
	assign db      = DEN_W'(seg_d1_q) - DEN_W'(seg_d_q);
	assign pb      = db * seg_s0_q;

	assign div_start = (state_q == S_DIV);
	assign out_free  = !m_tvalid_q || m_tready;

	plm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && in_op == OP_QUERY) begin
						state_q <= S_CHAIN;
					end
				end
				S_CHAIN: begin
					if (tok_end.vld) begin
						seg_d_q   <= tok_end.d;
						seg_d0_q  <= tok_end.d0;
						seg_d1_q  <= tok_end.d1;
						seg_s0_q  <= tok_end.s0;
						seg_s1_q  <= tok_end.s1;
						den_q     <= wd;
						if (tok_end.done && tok_end.seg && wd != '0) begin
							state_q <= S_MUL0;
						end else begin
							state_q <= S_OUT;
						end
						if (tok_end.done) begin
							res_sat_q   <= 1'b0;
							res_steer_q <= (tok_end.seg && wd == '0) ? tok_end.s0 : '0;
						end else if (tok_end.d >= tok_end.prev.pd) begin
							res_steer_q <= tok_end.prev.ps;
							res_sat_q   <= 1'b1;
						end else if (tok_end.d <= tok_end.prev.nd) begin
							res_steer_q <= tok_end.prev.ns;
							res_sat_q   <= 1'b1;
						end else begin
							res_steer_q <= '0;
							res_sat_q   <= 1'b0;
						end
					end
				end
				S_MUL0: begin
					prod_q  <= da * seg_s1_q;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					num_q   <= NUM_W'(prod_q) + NUM_W'(pb);
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						res_steer_q <= div_quo;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_steer_q;
						m_tuser_q  <= res_sat_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ----- hw/rtl/plm_chk.sv -----
// ----------------------------------------------------------------------------
// plm_chk
// Port-level checks of the two-sided piecewise linear map, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [plm_pkg::S_TDATA_W-1:0]   s_tdata,
	input wire logic [plm_pkg::S_TUSER_W-1:0]   s_tuser,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [plm_pkg::M_TDATA_W-1:0]   m_tdata,
	input wire logic [plm_pkg::M_TUSER_W-1:0]   m_tuser
);
	import plm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != OP_QUERY |=> s_tready)
		else $error("not ready after a load word");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_QUERY |=> !s_tready)
		else $error("ready right after a query word");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a query in flight");

	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown({s_tdata, s_tuser}))
		else $error("input word unknown");

endmodule

bind two_sided_piecewise_linear_map plm_chk u_plm_chk (.*);

`default_nettype wire
